@@ rtl/pi_throttle_controller_assert.svh @@
// Assertion macros shared by the throttle controller RTL.
// Included by files that carry concurrent checks; depends on nothing.
`ifndef PI_THROTTLE_CONTROLLER_ASSERT_SVH
`define PI_THROTTLE_CONTROLLER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PITC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define PITC_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/pitc_pkg.sv @@
// Package for the PI throttle controller: command and register codes,
// field widths and operand types. Depends on nothing.
package pitc_pkg;

  localparam int CmdW   = 2;
  localparam int EnergyW = 32;
  localparam int TimeW  = 32;
  localparam int ThrW   = 17;
  localparam int GainW  = 24;
  localparam int LimW   = 31;
  localparam int IdxW   = 3;
  localparam int CfgW   = 32;
  localparam int DtW    = 17;

  localparam int MulAW  = 33;
  localparam int MulBW  = 25;
  localparam int MulPW  = MulAW + MulBW;
  localparam int QShift = 16;

  localparam logic [CmdW-1:0] CMD_SET_REF  = 2'd0;
  localparam logic [CmdW-1:0] CMD_SET_MEAS = 2'd1;
  localparam logic [CmdW-1:0] CMD_TICK     = 2'd2;

  localparam logic [IdxW-1:0] REG_PROP_GAIN     = 3'd0;
  localparam logic [IdxW-1:0] REG_INTEGRAL_GAIN = 3'd1;
  localparam logic [IdxW-1:0] REG_CEILING       = 3'd2;
  localparam logic [IdxW-1:0] REG_FLOOR         = 3'd3;
  localparam logic [IdxW-1:0] REG_FEEDFORWARD   = 3'd4;
  localparam logic [IdxW-1:0] REG_INTEGRAL_LIM  = 3'd5;

  localparam logic signed [EnergyW-1:0] STOP_CODE  = -32'sd65536;
  localparam logic [TimeW-1:0]          ONE_SECOND = 32'd65536;

  typedef logic signed [MulAW-1:0] mul_a_t;
  typedef logic signed [MulBW-1:0] mul_b_t;
  typedef logic signed [MulPW-1:0] mul_p_t;

endpackage

@@ rtl/pitc_mul.sv @@
// Shared signed multiplier of the PI throttle controller, product registered.
// Depends on pitc_pkg.
module pitc_mul (
  input  logic             clk,
  input  logic             en,
  input  pitc_pkg::mul_a_t a,
  input  pitc_pkg::mul_b_t b,
  output pitc_pkg::mul_p_t p
);
  import pitc_pkg::*;

  always_ff @(posedge clk) begin
    if (en) begin
      p <= MulPW'(a) * MulPW'(b);
    end
  end

endmodule

@@ rtl/pi_throttle_controller.sv @@
// Top level of the PI throttle controller: command decode, state, sequencer.
// Depends on pitc_pkg, pitc_mul and pi_throttle_controller_assert.svh.
//
// Input stream: s_axis_tuser carries the command (set reference, set
// measurement, tick), s_axis_tdata the energy value and the tick timestamp.
// Set commands update state in the cycle they are accepted and produce no
// output. A tick that passes the checks runs the steps ST_ERRDT, ST_KP, ST_KI
// and ST_SUM through one shared multiplier (error times interval, proportional
// term, integral term, final sum and clamp). The result is loaded as ST_SUM
// returns to idle, and the input takes no new tick until then.
// A tick while stopped gives its result the cycle after acceptance. The input
// is not ready while a tick is being worked on, nor while the output register
// is full and not being taken.
// Output stream: m_axis_tdata carries the throttle, m_axis_tuser the stopped
// flag; the result stays in the output register until the receiver takes
// it, and a computed result waits in the last step if the receiver stalls.
// The configuration channel is always ready; write it only while idle, which the block does not enforce.
// Reset clears the sequencer, the levels, the integral, the tick time and the
// flags, loads the default gains and limits, and empties the output register.
`include "pi_throttle_controller_assert.svh"

module pi_throttle_controller (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [63:0]                s_axis_tdata,  // energy_value, tick_time
  input  logic [pitc_pkg::CmdW-1:0]  s_axis_tuser,  // cmd
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [23:0]                m_axis_tdata,  // throttle
  output logic                       m_axis_tuser,  // stopped
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [pitc_pkg::IdxW-1:0]  cfg_index,
  input  logic [pitc_pkg::CfgW-1:0]  cfg_data
);
  import pitc_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ERRDT = 3'd1;
  localparam logic [2:0] ST_KP    = 3'd2;
  localparam logic [2:0] ST_KI    = 3'd3;
  localparam logic [2:0] ST_SUM   = 3'd4;

  logic [2:0] state;

  logic [GainW-1:0] prop_gain;
  logic [GainW-1:0] integral_gain;
  logic [ThrW-1:0]  throttle_ceiling;
  logic [ThrW-1:0]  throttle_floor;
  logic [ThrW-1:0]  feedforward_throttle;
  logic [LimW-1:0]  integral_limit;

  logic signed [EnergyW-1:0] reference_level;
  logic signed [EnergyW-1:0] measured_level;
  logic signed [EnergyW-1:0] error_integral;
  logic [TimeW-1:0]          previous_tick_time;
  logic                      reference_seen;
  logic                      measurement_seen;
  logic                      stop_request;

  logic signed [MulAW-1:0] err;
  logic [DtW-1:0]          dt_r;
  logic signed [43:0]      acc;
  logic [ThrW-1:0]         throttle;
  logic                    stopped;

  logic [CmdW-1:0]           in_cmd;
  logic signed [EnergyW-1:0] in_energy;
  logic [TimeW-1:0]          in_time;
  logic                      in_xfer;
  logic                      out_free;
  logic                      out_load;
  logic [TimeW-1:0]          dt;
  logic                      dt_ok;

  logic                    mul_en;
  mul_a_t                  mul_a;
  mul_b_t                  mul_b;
  mul_p_t                  prod;
  logic signed [41:0]      prod_q;

  logic signed [42:0] isum;
  logic signed [42:0] ilim;
  logic signed [42:0] iclamp;
  logic signed [43:0] total;
  logic signed [43:0] hi;
  logic signed [43:0] lo;
  logic signed [43:0] capped;
  logic signed [43:0] result;

  assign in_cmd    = s_axis_tuser;
  assign in_energy = s_axis_tdata[31:0];
  assign in_time   = s_axis_tdata[63:32];

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = (state == ST_IDLE) && out_free;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;

  assign out_load = ((state == ST_IDLE) && in_xfer && (in_cmd == CMD_TICK) && reference_seen
                     && measurement_seen && stop_request) || ((state == ST_SUM) && out_free);

  assign dt    = in_time - previous_tick_time;
  assign dt_ok = (dt != '0) && (dt <= ONE_SECOND);

  assign prod_q = prod[MulPW-1:QShift];

  always_comb begin
    mul_en = 1'b0;
    mul_a  = err;
    mul_b  = MulBW'({8'b0, dt_r});
    case (state)
      ST_ERRDT: begin
        mul_en = 1'b1;
      end
      ST_KP: begin
        mul_en = 1'b1;
        mul_b  = MulBW'({1'b0, prop_gain});
      end
      ST_KI: begin
        mul_en = 1'b1;
        mul_a  = {error_integral[EnergyW-1], error_integral};
        mul_b  = MulBW'({1'b0, integral_gain});
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  pitc_mul u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  always_comb begin
    isum = {{11{error_integral[EnergyW-1]}}, error_integral} + {prod_q[41], prod_q};
    ilim = {12'b0, integral_limit};
    if (isum > ilim) begin
      iclamp = ilim;
    end else if (isum < -ilim) begin
      iclamp = -ilim;
    end else begin
      iclamp = isum;
    end
  end

  always_comb begin
    total  = acc + {{2{prod_q[41]}}, prod_q};
    hi     = {27'b0, throttle_ceiling};
    lo     = {27'b0, throttle_floor};
    capped = (total > hi) ? hi : total;
    result = (capped < lo) ? lo : capped;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain            <= GainW'(32768);
      integral_gain        <= GainW'(6554);
      throttle_ceiling     <= ThrW'(65536);
      throttle_floor       <= '0;
      feedforward_throttle <= ThrW'(26214);
      integral_limit       <= LimW'(32768);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PROP_GAIN:     prop_gain            <= cfg_data[GainW-1:0];
        REG_INTEGRAL_GAIN: integral_gain        <= cfg_data[GainW-1:0];
        REG_CEILING:       throttle_ceiling     <= cfg_data[ThrW-1:0];
        REG_FLOOR:         throttle_floor       <= cfg_data[ThrW-1:0];
        REG_FEEDFORWARD:   feedforward_throttle <= cfg_data[ThrW-1:0];
        REG_INTEGRAL_LIM:  integral_limit       <= cfg_data[LimW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= ST_IDLE;
      reference_level    <= '0;
      measured_level     <= '0;
      error_integral     <= '0;
      previous_tick_time <= '0;
      reference_seen     <= 1'b0;
      measurement_seen   <= 1'b0;
      stop_request       <= 1'b0;
      m_axis_tvalid      <= 1'b0;
    end else begin
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            case (in_cmd)
              CMD_SET_REF: begin
                reference_level <= in_energy;
                reference_seen  <= 1'b1;
                stop_request    <= (in_energy == STOP_CODE);
              end
              CMD_SET_MEAS: begin
                measured_level   <= in_energy;
                measurement_seen <= 1'b1;
              end
              CMD_TICK: begin
                if (reference_seen && measurement_seen && !stop_request) begin
                  previous_tick_time <= in_time;
                  if (dt_ok) begin
                    state <= ST_ERRDT;
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_ERRDT: state <= ST_KP;
        ST_KP: begin
          error_integral <= iclamp[EnergyW-1:0];
          state          <= ST_KI;
        end
        ST_KI: state <= ST_SUM;
        ST_SUM: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_xfer && in_cmd == CMD_TICK) begin
      err      <= {reference_level[EnergyW-1], reference_level}
                - {measured_level[EnergyW-1], measured_level};
      dt_r     <= dt[DtW-1:0];
      throttle <= '0;
      stopped  <= 1'b1;
    end
    if (state == ST_KI) begin
      acc <= {27'b0, feedforward_throttle} + {{2{prod_q[41]}}, prod_q};
    end
    if (state == ST_SUM && out_free) begin
      throttle <= result[ThrW-1:0];
      stopped  <= 1'b0;
    end
  end

  assign m_axis_tdata = {7'b0, throttle};
  assign m_axis_tuser = stopped;

  `PITC_ASSERT_NXT(a_seq_order, clk, rst, state == ST_ERRDT, state == ST_KP, "sequencer skipped a step")
  `PITC_ASSERT_NXT(a_sum_out, clk, rst, (state == ST_SUM) && out_free, m_axis_tvalid && !m_axis_tuser, "computed result not presented")
  `PITC_ASSERT_IMP(a_stop_zero, clk, rst, m_axis_tvalid && m_axis_tuser, m_axis_tdata == 24'd0, "stopped result carries nonzero throttle")
  `PITC_ASSERT_IMP(a_clamp, clk, rst, m_axis_tvalid && !m_axis_tuser, (throttle == throttle_floor) || ((throttle <= throttle_ceiling) && (throttle >= throttle_floor)), "throttle outside its clamp range")

endmodule
